[rtl/lru_tile_cache_directory_core_defines.svh]
// Assertion macros shared by the directory core.
`ifndef LRU_TILE_CACHE_DIRECTORY_CORE_DEFINES_SVH
`define LRU_TILE_CACHE_DIRECTORY_CORE_DEFINES_SVH

// Plain property, checked at every clock edge out of reset.
`define LRUTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define LRUTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRUTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lrutc_pkg.sv]
`timescale 1ns / 1ps
package lrutc_pkg;

  // Number of directory cells
  localparam int unsigned CacheEntries = 128;

  localparam int unsigned ColW   = 16;
  localparam int unsigned RowW   = 16;
  localparam int unsigned LayerW = 5;
  localparam int unsigned PhaseW = 2;

  // Entry phase codes
  localparam logic [PhaseW-1:0] PhLoading = 2'd0;
  localparam logic [PhaseW-1:0] PhWaiting = 2'd1;
  localparam logic [PhaseW-1:0] PhReady   = 2'd2;

  typedef enum logic [2:0] {
    StHitReady    = 3'd0,
    StHitUpload   = 3'd1,
    StPending     = 3'd2,
    StMiss        = 3'd3,
    StMissEvict   = 3'd4,
    StDoneApplied = 3'd5,
    StDoneDropped = 3'd6
  } status_e;

  typedef enum logic {
    FsmIdle = 1'b0,
    FsmExec = 1'b1
  } fsm_e;

  typedef struct packed {
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [LayerW-1:0] layer;
  } key_t;

  typedef struct packed {
    logic              valid;
    key_t              key;
    logic [PhaseW-1:0] phase;
  } entry_t;

  // Per-cell update controls
  typedef struct packed {
    logic shift;        // take the neighbor's entry
    logic set_waiting;  // mark own entry waiting if it matched
  } cell_ctrl_t;

endpackage

[rtl/lrutc_cell.sv]
`timescale 1ns / 1ps
module lrutc_cell
  import lrutc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmp_en_i,
  input  key_t       key_i,
  input  entry_t     prev_i,
  input  cell_ctrl_t ctrl_i,
  output entry_t     entry_o,
  output logic       match_o
);

  logic              valid_q, valid_d;
  key_t              key_q, key_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              match_q, match_d;

  // Compare against the incoming key, update from neighbor or in place
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    phase_d = phase_q;
    match_d = match_q;
    if (cmp_en_i) begin
      match_d = valid_q && (key_q == key_i);
    end
    if (ctrl_i.shift) begin
      valid_d = prev_i.valid;
      key_d   = prev_i.key;
      phase_d = prev_i.phase;
    end else if (ctrl_i.set_waiting && match_q) begin
      phase_d = PhWaiting;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    phase_q <= phase_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, phase: phase_q};
  assign match_o = match_q;

endmodule

[rtl/lru_tile_cache_directory_core.sv]
// Each item runs compare, then update; the result is registered with the update.
// A new item is taken only after the last one's update; each cell registers its key
// compare in the accept cycle; the cell row's shift/phase update lands in Exec.
// A full result register stalls the update cycle until the result is taken.
// Reset clears the control state and every cell's valid bit; no clearing pass.
`timescale 1ns / 1ps
module lru_tile_cache_directory_core
  import lrutc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [ColW-1:0]   tile_col_i,
  input  logic [RowW-1:0]   tile_row_i,
  input  logic [LayerW-1:0] layer_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [ColW-1:0]   victim_col_o,
  output logic [RowW-1:0]   victim_row_o,
  output logic [LayerW-1:0] victim_layer_o,
  output logic [PhaseW-1:0] victim_state_o
);

`include "lru_tile_cache_directory_core_defines.svh"

  fsm_e state_q, state_d;
  logic op_q;
  key_t key_q, in_key;
  logic in_fire, exec_fire;

  entry_t     entries [CacheEntries];
  entry_t     prevs   [CacheEntries];
  cell_ctrl_t ctrls   [CacheEntries];
  logic [CacheEntries-1:0] match_vec, suffix_vec, valid_vec;

  logic              hit;
  logic [PhaseW-1:0] hit_phase;
  logic              full;
  logic              do_miss, do_front;
  entry_t            front;

  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  entry_t            victim_q, victim_d;

  assign in_key  = '{col: tile_col_i, row: tile_row_i, layer: layer_index_i};
  assign in_ready_o = (state_q == FsmIdle);
  assign in_fire = in_valid_i && in_ready_o;
  assign exec_fire = (state_q == FsmExec) && (!out_valid_q || out_ready_i);

  // Cell row: cell 0 takes the front entry, others take their neighbor
  for (genvar g = 0; g < CacheEntries; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prevs[g] = front;
    end else begin : g_body
      assign prevs[g] = entries[g-1];
    end
    lrutc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmp_en_i (in_fire),
      .key_i    (in_key),
      .prev_i   (prevs[g]),
      .ctrl_i   (ctrls[g]),
      .entry_o  (entries[g]),
      .match_o  (match_vec[g])
    );
    assign valid_vec[g] = entries[g].valid;
  end

  // Match summary: hit, matched phase, and "match at or behind" per cell
  always_comb begin
    hit_phase = '0;
    suffix_vec[CacheEntries-1] = match_vec[CacheEntries-1];
    for (int i = CacheEntries - 2; i >= 0; i--) begin
      suffix_vec[i] = match_vec[i] | suffix_vec[i+1];
    end
    for (int i = 0; i < CacheEntries; i++) begin
      hit_phase = hit_phase | (entries[i].phase & {PhaseW{match_vec[i]}});
    end
  end

  assign hit  = suffix_vec[0];
  assign full = valid_vec[CacheEntries-1];
  assign do_miss  = !op_q && !hit;
  assign do_front = !op_q && hit && (hit_phase != PhLoading);

  // Entry inserted at the front
  always_comb begin
    front.valid = 1'b1;
    front.key   = key_q;
    if (do_miss) begin
      front.phase = PhLoading;
    end else if (hit_phase == PhWaiting) begin
      front.phase = PhReady;
    end else begin
      front.phase = hit_phase;
    end
  end

  // Cell controls, only in the update cycle
  always_comb begin
    for (int i = 0; i < CacheEntries; i++) begin
      ctrls[i].shift       = exec_fire && (do_miss || (do_front && suffix_vec[i]));
      ctrls[i].set_waiting = exec_fire && op_q;
    end
  end

  // Result
  always_comb begin
    victim_d = '0;
    if (op_q) begin
      status_d = hit ? StDoneApplied : StDoneDropped;
    end else if (hit) begin
      case (hit_phase)
        PhLoading: status_d = StPending;
        PhWaiting: status_d = StHitUpload;
        default:   status_d = StHitReady;
      endcase
    end else if (full) begin
      status_d = StMissEvict;
      victim_d = entries[CacheEntries-1];
    end else begin
      status_d = StMiss;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      FsmIdle: begin
        if (in_fire) begin
          state_d = FsmExec;
        end
      end
      FsmExec: begin
        if (exec_fire) begin
          state_d     = FsmIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = FsmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_i;
      key_q <= in_key;
    end
    if (exec_fire) begin
      status_q <= status_d;
      victim_q <= victim_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign victim_col_o   = victim_q.key.col;
  assign victim_row_o   = victim_q.key.row;
  assign victim_layer_o = victim_q.key.layer;
  assign victim_state_o = victim_q.phase;

  // Checks
  `LRUTC_ASSERT_IMP(a_unique_match, state_q == FsmExec, $onehot0(match_vec),
                    "more than one cell matched the key")
  `LRUTC_ASSERT(a_valid_prefix,
                $onehot({1'b0, valid_vec} + {{CacheEntries{1'b0}}, 1'b1}),
                "valid cells do not form a prefix of the row")
  `LRUTC_ASSERT_NXT(a_two_cycle, in_fire, !in_ready_o,
                    "input taken again right after an accept")

endmodule
